@@ hw/rtl/lprt_pkg.sv @@
// shared types, constants and helpers of the route table
`timescale 1ns / 1ps
package lprt_pkg;
	localparam int SLOTS = 64;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_DEL    = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EXISTS    = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_NO_ROUTE  = 3'd4;

	typedef struct packed {
		logic [31:0] net;
		logic [5:0]  plen;
		logic [31:0] hop;
	} route_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic shift;
		logic shift_init;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic is_delete;
		logic out_free;
	} stat_t;

	function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
		logic [31:0] m;
		begin
			if (plen >= 6'd32) begin
				m = 32'hFFFF_FFFF;
			end else begin
				m = ~(32'hFFFF_FFFF >> plen);
			end
			return m;
		end
	endfunction
endpackage

@@ hw/rtl/longest_prefix_route_table.sv @@
// Longest-prefix IPv4 route table: one item at a time, scanning a route memory
// with one read port, one slot per cycle. A delete that hits then shifts the
// later routes down one slot. The result register frees the input side as
// soon as a result is written, so the next transfer can start while the
// previous result waits.
`timescale 1ns / 1ps
module longest_prefix_route_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] dest_addr,
	input  logic [5:0]  prefix_len,
	input  logic [31:0] gateway,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] next_hop,
	output logic [6:0]  route_count
);
	import lprt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lprt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lprt_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.dest_addr   (dest_addr),
		.prefix_len  (prefix_len),
		.gateway     (gateway),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.next_hop    (next_hop),
		.route_count (route_count)
	);
endmodule

@@ hw/rtl/lprt_ctrl.sv @@
// controller state machine of the route table
`timescale 1ns / 1ps
module lprt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lprt_pkg::stat_t stat,
	output lprt_pkg::cmd_t  cmd
);
	import lprt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					if (stat.is_delete && stat.found) begin
						cmd.shift_init = 1'b1;
						state_d = S_SHIFT;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_SHIFT: begin
				cmd.scan = 1'b1;
				cmd.shift = 1'b1;
				if (stat.scan_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

@@ hw/rtl/lprt_datapath.sv @@
// route memory, slot scan, shift-down and result register
`timescale 1ns / 1ps
module lprt_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lprt_pkg::cmd_t          cmd,
	output lprt_pkg::stat_t         stat,
	input  logic [1:0]              kind,
	input  logic [31:0]             dest_addr,
	input  logic [5:0]              prefix_len,
	input  logic [31:0]             gateway,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              status,
	output logic [31:0]             next_hop,
	output logic [6:0]              route_count
);
	import lprt_pkg::*;

	route_t mem [SLOTS];

	logic [1:0]       kind_q;
	logic [31:0]      addr_q, net_q, gw_q;
	logic [5:0]       plen_q;
	logic [CNT_W-1:0] cnt_q, rd_idx_q, rd_idx_s1;
	logic             rd_vld_s1;
	route_t           rd_data_s1;
	logic             found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [5:0]       best_len_q;
	logic [31:0]      best_hop_q;
	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [31:0]      hop_q;
	logic [6:0]       count_q;

	logic [5:0]       plen_sat;
	logic             rd_en, wr_en;
	logic [IDX_W-1:0] wr_addr;
	route_t           wr_data;
	logic             add_ok;
	logic             exact_hit, cover_hit;
	logic [CNT_W-1:0] cnt_next;
	logic [2:0]       status_d;
	logic [31:0]      hop_d;

	assign plen_sat = (prefix_len > 6'd32) ? 6'd32 : prefix_len;
	assign rd_en = cmd.scan && (rd_idx_q < cnt_q);
	assign add_ok = (kind_q == KIND_ADD) && !found_q && (cnt_q < CNT_W'(SLOTS));

	assign exact_hit = (rd_data_s1.plen == plen_q) && (rd_data_s1.net == net_q) &&
		(rd_data_s1.hop == gw_q);
	assign cover_hit = ((rd_data_s1.net ^ addr_q) & prefix_mask(rd_data_s1.plen)) == 32'd0;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cnt_q[IDX_W-1:0];
		wr_data = '{net: net_q, plen: plen_q, hop: gw_q};
		if (cmd.shift && rd_vld_s1) begin
			wr_en = 1'b1;
			wr_addr = IDX_W'(rd_idx_s1 - CNT_W'(1));
			wr_data = rd_data_s1;
		end else if (cmd.finish && add_ok) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	always_comb begin
		cnt_next = cnt_q;
		status_d = ST_OK;
		hop_d = 32'd0;
		case (kind_q)
			KIND_ADD: begin
				if (found_q) begin
					status_d = ST_EXISTS;
				end else if (!add_ok) begin
					status_d = ST_FULL;
				end else begin
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			KIND_DEL: begin
				if (found_q) begin
					cnt_next = cnt_q - CNT_W'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			KIND_LOOKUP: begin
				if (found_q) begin
					hop_d = (best_hop_q == 32'd0) ? addr_q : best_hop_q;
				end else begin
					status_d = ST_NO_ROUTE;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q <= kind;
			addr_q <= dest_addr;
			plen_q <= plen_sat;
			gw_q <= gateway;
			net_q <= dest_addr & prefix_mask(plen_sat);
		end
		if (rd_en) begin
			rd_idx_s1 <= rd_idx_q;
		end
		if (cmd.scan && !cmd.shift && rd_vld_s1) begin
			if (kind_q == KIND_LOOKUP) begin
				if (cover_hit && (!found_q || rd_data_s1.plen >= best_len_q)) begin
					best_len_q <= rd_data_s1.plen;
					best_hop_q <= rd_data_s1.hop;
				end
			end else if (exact_hit) begin
				hit_idx_q <= rd_idx_s1[IDX_W-1:0];
			end
		end
		if (cmd.finish) begin
			status_q <= status_d;
			hop_q <= hop_d;
			count_q <= 7'(cnt_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				rd_idx_q <= '0;
				rd_vld_s1 <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.shift_init) begin
				rd_idx_q <= CNT_W'(hit_idx_q) + CNT_W'(1);
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (!cmd.shift && rd_vld_s1) begin
					if (kind_q == KIND_LOOKUP) begin
						if (cover_hit) begin
							found_q <= 1'b1;
						end
					end else if (exact_hit) begin
						found_q <= 1'b1;
					end
				end
			end
			if (cmd.finish) begin
				cnt_q <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.scan_done = (rd_idx_q == cnt_q) && !rd_vld_s1;
	assign stat.found = found_q;
	assign stat.is_delete = (kind_q == KIND_DEL);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign next_hop = hop_q;
	assign route_count = count_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(SLOTS))
		else $error("route count beyond table size");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> rd_idx_q <= cnt_q)
		else $error("slot read beyond held routes");
	a_hit_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_init |-> CNT_W'(hit_idx_q) < cnt_q)
		else $error("delete hit outside held routes");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transfer");
endmodule
